>>> rtl/temperature_average_convert_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the temperature averaging and conversion block
// Short forms for the concurrent assertions written against clk_i and rst_ni.
// ---------------------------------------------------------------------------
`ifndef TEMPERATURE_AVERAGE_CONVERT_TOP_MACROS_SVH
`define TEMPERATURE_AVERAGE_CONVERT_TOP_MACROS_SVH

// Checked on every rising edge while the block is out of reset.
`define TAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define TAC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/tac_pkg.sv
// ---------------------------------------------------------------------------
// Temperature averaging and conversion package
// Widths, default parameters, calibration constants and shared types.
// ---------------------------------------------------------------------------
package tac_pkg;

  localparam int SampleBits = 12;
  localparam int TempBits   = 15;
  localparam int CfgIdxW    = 2;

  localparam int DefWindow  = 5;
  localparam int DefPeriod  = 256;

  // Datapath widths: accumulator, divider numerator and divisor, multiplier.
  localparam int AccW  = 24;
  localparam int NumW  = 23;
  localparam int DenW  = 12;
  localparam int MulAW = 13;
  localparam int MulBW = 10;

  // Tenths of a degree: C = 30 + 55 * x / d, F = C * 1.8 + 32.
  localparam int TempLimit = 9999;
  localparam int CelGain   = 550;
  localparam int CelOffs   = 300;
  localparam int FahGain   = 990;
  localparam int FahOffs   = 860;

  localparam logic [CfgIdxW-1:0] CfgRegR30 = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRegR85 = 2'd1;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

endpackage

>>> rtl/tac_if.sv
// ---------------------------------------------------------------------------
// Temperature averaging and conversion channel interfaces
// Sample input, result output and configuration write channels.
// ---------------------------------------------------------------------------
interface tac_in_if;
  logic                           valid;
  logic                           ready;
  logic [tac_pkg::SampleBits-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface tac_out_if;
  logic                                valid;
  logic                                ready;
  logic        [tac_pkg::SampleBits-1:0] averaged_reading;
  logic signed [tac_pkg::TempBits-1:0]   celsius_tenths;
  logic signed [tac_pkg::TempBits-1:0]   fahrenheit_tenths;
  logic                                  calibration_invalid;

  modport source (output valid, output averaged_reading, output celsius_tenths,
                  output fahrenheit_tenths, output calibration_invalid, input ready);
  modport sink   (input valid, input averaged_reading, input celsius_tenths,
                  input fahrenheit_tenths, input calibration_invalid, output ready);
endinterface

interface tac_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tac_pkg::CfgIdxW-1:0]    index;
  logic [tac_pkg::SampleBits-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/tac_div.sv
// ---------------------------------------------------------------------------
// Shared iterative divider
// Unsigned restoring division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module tac_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tac_pkg::div_req_t         req_i,
  output logic                      done_o,
  output logic [tac_pkg::NumW-1:0]  quo_o
);

  localparam int NumW = tac_pkg::NumW;
  localparam int DenW = tac_pkg::DenW;
  localparam int CntW = $clog2(NumW);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [NumW-1:0] quo_q;
  logic [DenW-1:0] rem_q;
  logic [DenW-1:0] den_q;

  logic [DenW:0]   rem_sh;
  logic [DenW+1:0] diff;
  logic            take;

  // The partial remainder always stays below the divisor.
  assign rem_sh = {rem_q, quo_q[NumW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
  assign take   = !diff[DenW+1];
  assign done_o = busy_q && (cnt_q == CntW'(NumW - 1));
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (done_o) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.num;
      rem_q <= '0;
      den_q <= req_i.den;
    end else if (busy_q) begin
      quo_q <= {quo_q[NumW-2:0], take};
      rem_q <= take ? diff[DenW-1:0] : rem_sh[DenW-1:0];
    end
  end

endmodule

>>> rtl/temperature_average_convert_top.sv
// ---------------------------------------------------------------------------
// Temperature averaging and conversion, top level
// Running average of sensor samples with two-point calibration to tenths of
// a degree Celsius and Fahrenheit.
// ---------------------------------------------------------------------------
// Each input word carries one raw sensor sample and gives exactly one result
// word. The average is cumulative over the first WINDOW samples of a period
// and then slides over the last WINDOW samples; every PERIOD samples it starts
// again from the new sample. With valid calibration (the 85 C reading above
// the 30 C reading) the average is turned into tenths of a degree Celsius and
// Fahrenheit, truncated toward zero and saturated to plus or minus 9999;
// otherwise calibration_invalid is set and both temperatures are zero. One
// multiply-accumulate unit builds each numerator and one shared restoring
// divider produces 23 quotient bits at one bit per cycle, three times per
// word (average, Celsius, Fahrenheit) with valid calibration and once, for
// the average, with invalid calibration. A word is not passed on to the
// output register until a previous result still waiting there is taken.
// The input is not ready while a word is being worked on; a finished
// result sits in the output register, so the next input word is accepted
// while it waits. Configuration writes are always accepted and must be made
// only while the block is idle.
module temperature_average_convert_top #(
  parameter int WINDOW = tac_pkg::DefWindow,
  parameter int PERIOD = tac_pkg::DefPeriod
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tac_in_if.sink     in_i,
  tac_out_if.source  out_o,
  tac_cfg_if.sink    cfg_i
);

  localparam int SW      = tac_pkg::SampleBits;
  localparam int TW      = tac_pkg::TempBits;
  localparam int AccW    = tac_pkg::AccW;
  localparam int NumW    = tac_pkg::NumW;
  localparam int DenW    = tac_pkg::DenW;
  localparam int MulAW   = tac_pkg::MulAW;
  localparam int MulBW   = tac_pkg::MulBW;
  localparam int IdxW    = $clog2(PERIOD);
  localparam int CntW    = $clog2(WINDOW + 1);
  localparam int SlotW   = $clog2(WINDOW);
  localparam int SMax    = (1 << SW) - 1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MAC1   = 7'b0000010,
    S_MAC2   = 7'b0000100,
    S_DLOAD  = 7'b0001000,
    S_DRUN   = 7'b0010000,
    S_POST   = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_e;

  typedef enum logic [1:0] {
    PH_AVG = 2'd0,
    PH_CEL = 2'd1,
    PH_FAH = 2'd2
  } phase_e;

  // Control state.
  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [SW-1:0]     prev_q, prev_d;
  logic [SW-1:0]     r30_q, r85_q;
  logic              out_valid_q, out_valid_d;

  // Working registers; their contents only matter once written for a word.
  logic [SW-1:0]            sample_q;
  logic signed [AccW-1:0]   acc_q;
  logic                     neg_q;
  logic [SW-1:0]            avg_q;
  logic signed [TW-1:0]     cel_q;
  logic signed [TW-1:0]     fah_q;
  logic                     inv_q;
  logic [SW-1:0]            recent_q [WINDOW];

  // Output register.
  logic [SW-1:0]            avg_out_q;
  logic signed [TW-1:0]     cel_out_q;
  logic signed [TW-1:0]     fah_out_q;
  logic                     inv_out_q;

  logic                     in_acc;
  logic                     sliding;
  logic [CntW-1:0]          jsel;
  logic [SW-1:0]            oldest;
  logic signed [MulAW-1:0]  x_s;
  logic signed [MulAW-1:0]  d_s;
  logic signed [MulAW-1:0]  mul_a;
  logic [MulBW-1:0]         mul_b;
  logic signed [AccW-1:0]   addend;
  logic signed [AccW-1:0]   prod;
  logic signed [AccW-1:0]   mac_sum;
  logic signed [AccW-1:0]   acc_mag;
  logic                     acc_neg;
  logic                     wrap;
  logic                     out_load;
  logic [SW-1:0]            avg_sat;
  logic [NumW-1:0]          temp_mag;
  logic signed [TW-1:0]     temp_val;

  tac_pkg::div_req_t        div_req;
  logic                     div_done;
  logic [NumW-1:0]          div_quo;

  assign in_acc      = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // The ring is always full once the index has passed the window, since
  // every period starts again at slot zero.
  assign sliding = ({1'b0, idx_q} >= (IdxW + 1)'(WINDOW));
  assign jsel    = CntW'(idx_q);
  assign oldest  = recent_q[slot_q];
  assign wrap    = (idx_q == IdxW'(PERIOD - 1));

  assign x_s = $signed({1'b0, avg_q}) - $signed({1'b0, r30_q});
  assign d_s = $signed({1'b0, r85_q}) - $signed({1'b0, r30_q});

  // Multiply-accumulate unit. For the average it forms prev * j + sample
  // (cumulative) or prev * WINDOW - oldest + sample (sliding); for the
  // temperatures it takes two passes, gain * x and then offset * d.
  always_comb begin
    mul_a  = $signed({1'b0, prev_q});
    mul_b  = MulBW'(WINDOW);
    addend = '0;
    if (state_q == S_MAC2) begin
      mul_a  = d_s;
      mul_b  = (phase_q == PH_CEL) ? MulBW'(tac_pkg::CelOffs) : MulBW'(tac_pkg::FahOffs);
      addend = acc_q;
    end else begin
      case (phase_q)
        PH_CEL: begin
          mul_a = x_s;
          mul_b = MulBW'(tac_pkg::CelGain);
        end
        PH_FAH: begin
          mul_a = x_s;
          mul_b = MulBW'(tac_pkg::FahGain);
        end
        default: begin
          mul_a  = $signed({1'b0, prev_q});
          mul_b  = sliding ? MulBW'(WINDOW) : MulBW'(jsel);
          addend = AccW'($signed({1'b0, sample_q}))
                   - (sliding ? AccW'($signed({1'b0, oldest})) : AccW'(0));
        end
      endcase
    end
    prod    = AccW'(mul_a) * AccW'($signed({1'b0, mul_b}));
    mac_sum = addend + prod;
  end

  // Divider feed: magnitude of the accumulator, sign kept aside. A negative
  // sliding sum clips the average to zero.
  assign acc_neg = acc_q[AccW-1];
  assign acc_mag = acc_neg ? -acc_q : acc_q;

  always_comb begin
    div_req.start = (state_q == S_DLOAD);
    div_req.num   = (phase_q == PH_AVG && acc_neg) ? '0 : acc_mag[NumW-1:0];
    if (phase_q == PH_AVG) begin
      div_req.den = sliding ? DenW'(WINDOW) : (DenW'(jsel) + DenW'(1));
    end else begin
      div_req.den = d_s[DenW-1:0];
    end
  end

  tac_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign avg_sat  = (div_quo > NumW'(SMax)) ? SW'(SMax) : div_quo[SW-1:0];
  assign temp_mag = (div_quo > NumW'(tac_pkg::TempLimit)) ? NumW'(tac_pkg::TempLimit)
                                                          : div_quo;
  assign temp_val = neg_q ? -$signed(TW'(temp_mag)) : $signed(TW'(temp_mag));

  assign out_load = (state_q == S_FINISH) && (!out_valid_q || out_o.ready);

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    idx_d       = idx_q;
    slot_d      = slot_q;
    prev_d      = prev_q;
    out_valid_d = out_valid_q && !out_o.ready;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          phase_d = PH_AVG;
          state_d = S_MAC1;
        end
      end
      S_MAC1: begin
        state_d = (phase_q == PH_AVG) ? S_DLOAD : S_MAC2;
      end
      S_MAC2: begin
        state_d = S_DLOAD;
      end
      S_DLOAD: begin
        state_d = S_DRUN;
      end
      S_DRUN: begin
        if (div_done) begin
          state_d = S_POST;
        end
      end
      S_POST: begin
        case (phase_q)
          PH_AVG: begin
            prev_d = avg_sat;
            idx_d  = wrap ? '0 : idx_q + IdxW'(1);
            slot_d = (wrap || slot_q == SlotW'(WINDOW - 1)) ? '0 : slot_q + SlotW'(1);
            if (r85_q <= r30_q) begin
              state_d = S_FINISH;
            end else begin
              phase_d = PH_CEL;
              state_d = S_MAC1;
            end
          end
          PH_CEL: begin
            phase_d = PH_FAH;
            state_d = S_MAC1;
          end
          default: begin
            state_d = S_FINISH;
          end
        endcase
      end
      S_FINISH: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_AVG;
      idx_q       <= '0;
      slot_q      <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
      r30_q       <= '0;
      r85_q       <= SW'(SMax);
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      slot_q      <= slot_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          tac_pkg::CfgRegR30: r30_q <= cfg_i.data;
          tac_pkg::CfgRegR85: r85_q <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= in_i.adc_sample;
    end
    if (state_q == S_MAC1 || state_q == S_MAC2) begin
      acc_q <= mac_sum;
    end
    if (state_q == S_DLOAD) begin
      neg_q <= acc_neg;
    end
    if (state_q == S_POST) begin
      case (phase_q)
        PH_AVG: begin
          avg_q            <= avg_sat;
          recent_q[slot_q] <= sample_q;
          inv_q            <= (r85_q <= r30_q);
          cel_q            <= '0;
          fah_q            <= '0;
        end
        PH_CEL:  cel_q <= temp_val;
        default: fah_q <= temp_val;
      endcase
    end
    if (out_load) begin
      avg_out_q <= avg_q;
      cel_out_q <= cel_q;
      fah_out_q <= fah_q;
      inv_out_q <= inv_q;
    end
  end

  assign out_o.valid               = out_valid_q;
  assign out_o.averaged_reading    = avg_out_q;
  assign out_o.celsius_tenths      = cel_out_q;
  assign out_o.fahrenheit_tenths   = fah_out_q;
  assign out_o.calibration_invalid = inv_out_q;

endmodule

>>> rtl/tac_chk.sv
// ---------------------------------------------------------------------------
// Temperature averaging and conversion checker
// Port-level checks on the top level, attached by bind.
// ---------------------------------------------------------------------------
`include "temperature_average_convert_top_macros.svh"

module tac_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_i,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic        [tac_pkg::SampleBits-1:0] averaged_reading_i,
  input logic signed [tac_pkg::TempBits-1:0]   celsius_tenths_i,
  input logic signed [tac_pkg::TempBits-1:0]   fahrenheit_tenths_i,
  input logic                                  calibration_invalid_i
);

  localparam logic signed [tac_pkg::TempBits-1:0] TempHi =
    tac_pkg::TempBits'(tac_pkg::TempLimit);
  localparam logic signed [tac_pkg::TempBits-1:0] TempLo = -TempHi;

  // A word is still being worked on after it is accepted, so the input closes straight after.
  property p_busy_after_accept;
    (in_valid_i && in_ready_i) |=> !in_ready_i;
  endproperty

  // A stalled result holds its word.
  property p_out_hold;
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(averaged_reading_i) && $stable(celsius_tenths_i)
       && $stable(fahrenheit_tenths_i) && $stable(calibration_invalid_i));
  endproperty

  // Invalid calibration gives zero temperatures.
  property p_inv_zero;
    (out_valid_i && calibration_invalid_i) |->
      (celsius_tenths_i == '0 && fahrenheit_tenths_i == '0);
  endproperty

  // Temperatures stay within the saturation limits.
  property p_temp_range;
    out_valid_i |->
      (celsius_tenths_i <= TempHi && celsius_tenths_i >= TempLo
       && fahrenheit_tenths_i <= TempHi && fahrenheit_tenths_i >= TempLo);
  endproperty

  `TAC_ASSERT(a_busy_after_accept, p_busy_after_accept, "input still ready after a word")
  `TAC_ASSERT(a_out_hold, p_out_hold, "stalled result changed")
  `TAC_ASSERT(a_inv_zero, p_inv_zero, "temperatures not zero with invalid calibration")
  `TAC_ASSERT(a_temp_range, p_temp_range, "temperature beyond saturation limit")

endmodule

bind temperature_average_convert_top tac_chk u_tac_chk (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .in_valid_i            (in_i.valid),
  .in_ready_i            (in_i.ready),
  .out_valid_i           (out_o.valid),
  .out_ready_i           (out_o.ready),
  .averaged_reading_i    (out_o.averaged_reading),
  .celsius_tenths_i      (out_o.celsius_tenths),
  .fahrenheit_tenths_i   (out_o.fahrenheit_tenths),
  .calibration_invalid_i (out_o.calibration_invalid)
);

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the temperature averaging and conversion block
// Drives raw sensor samples through several calibration settings and checks
// every result word, field by field, against an in-bench prediction of the
// running average and the Celsius and Fahrenheit conversion.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int WINDOW = tac_pkg::DefWindow;
  localparam int PERIOD = tac_pkg::DefPeriod;
  localparam int SB     = tac_pkg::SampleBits;
  localparam int TB_TW  = tac_pkg::TempBits;

  localparam int AvgMax = (1 << SB) - 1;

  // Ten calibration settings after the opening words; the last runs steady.
  localparam int NumPhases  = 10;
  localparam int PhaseWords = 93;

  // One result word as the block should give it.
  typedef struct packed {
    logic [SB-1:0]           avg;
    logic signed [TB_TW-1:0] cel;
    logic signed [TB_TW-1:0] fah;
    logic                    inv;
  } reading_t;

  logic clk_i;
  logic rst_ni;

  tac_in_if  in_if ();
  tac_out_if out_if ();
  tac_cfg_if cfg_if ();

  temperature_average_convert_top #(
    .WINDOW(WINDOW),
    .PERIOD(PERIOD)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // -------------------------------------------------------------------------
  // Clock
  // -------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // -------------------------------------------------------------------------
  // Predictor state: a copy of the averaging window and the calibration.
  // -------------------------------------------------------------------------
  logic [SB-1:0] recent [WINDOW] = '{default: '0};
  logic [SB-1:0] prev_avg = '0;
  int            win_pos = 0;
  logic [SB-1:0] cal_r30;
  logic [SB-1:0] cal_r85;

  // Words waiting to be sent, and readings waiting to come back.
  logic [SB-1:0] sample_q [$];
  reading_t      reading_q [$];

  int  words_in;
  int  results_seen;
  int  mismatches;
  int  n_invalid;
  int  n_saturated;
  int  n_floored;
  int  n_wraps;
  int  n_settings;
  bit  steady;
  int  sensor_level;

  // -------------------------------------------------------------------------
  // Overall time limit
  // -------------------------------------------------------------------------
  // The slowest correct run is roughly 950 words plus the idle bursts on
  // both sides and the long hold-off; five milliseconds leaves a margin of
  // several times that.
  initial begin : watchdog
    #5_000_000;
    $display("timeout: %0d words accepted, %0d results seen", words_in, results_seen);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic signed [TB_TW-1:0] clamp_tenths(input longint v);
    longint c;
    c = v;
    if (c > tac_pkg::TempLimit) c = tac_pkg::TempLimit;
    if (c < -tac_pkg::TempLimit) c = -tac_pkg::TempLimit;
    if (c != v) n_saturated++;
    return c[TB_TW-1:0];
  endfunction

  // Advances the averaging window by one sample and gives the reading that
  // the block must return for it.
  function automatic reading_t next_reading(input logic [SB-1:0] sample);
    longint   num;
    longint   avg;
    longint   span;
    longint   offs;
    int       slot;
    reading_t r;
    slot = win_pos % WINDOW;
    if (win_pos == 0) begin
      avg = longint'(sample);
    end else if (win_pos < WINDOW) begin
      // Still filling the window: a cumulative average.
      avg = (longint'(sample) + longint'(prev_avg) * win_pos) / (win_pos + 1);
    end else begin
      // Sliding: truncation drift can push the sum below zero.
      num = longint'(prev_avg) * WINDOW - longint'(recent[slot]) + longint'(sample);
      if (num < 0) begin
        num = 0;
        n_floored++;
      end
      avg = num / WINDOW;
    end
    if (avg > AvgMax) avg = AvgMax;

    recent[slot] = sample;
    prev_avg     = avg[SB-1:0];
    if (win_pos + 1 >= PERIOD) begin
      win_pos = 0;
      n_wraps++;
    end else begin
      win_pos = win_pos + 1;
    end

    r.avg = avg[SB-1:0];
    if (cal_r85 <= cal_r30) begin
      r.cel = '0;
      r.fah = '0;
      r.inv = 1'b1;
      n_invalid++;
    end else begin
      span  = longint'(cal_r85) - longint'(cal_r30);
      offs  = avg - longint'(cal_r30);
      // Signed division truncates toward zero, as the block must.
      r.cel = clamp_tenths((tac_pkg::CelGain * offs + tac_pkg::CelOffs * span) / span);
      r.fah = clamp_tenths((tac_pkg::FahGain * offs + tac_pkg::FahOffs * span) / span);
      r.inv = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    mismatches++;
    $display("mismatch at result %0d: %s is %0d, expected %0d",
             results_seen, field, got, want);
  endtask

  // -------------------------------------------------------------------------
  // Monitor: on every rising edge, an accepted input word is run through the
  // predictor and an accepted result word is checked against the oldest
  // reading still waiting.
  // -------------------------------------------------------------------------
  logic in_fire;

  always @(posedge clk_i) begin
    reading_t want;
    in_fire <= in_if.valid && in_if.ready;
    if (rst_ni && in_if.valid && in_if.ready) begin
      reading_q.push_back(next_reading(in_if.adc_sample));
      words_in++;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (reading_q.size() == 0) begin
        report_mismatch("unexpected result word", 1, 0);
      end else begin
        want = reading_q.pop_front();
        if (out_if.averaged_reading !== want.avg)
          report_mismatch("averaged_reading", out_if.averaged_reading, want.avg);
        if (out_if.celsius_tenths !== want.cel)
          report_mismatch("celsius_tenths", $signed(out_if.celsius_tenths),
                          $signed(want.cel));
        if (out_if.fahrenheit_tenths !== want.fah)
          report_mismatch("fahrenheit_tenths", $signed(out_if.fahrenheit_tenths),
                          $signed(want.fah));
        if (out_if.calibration_invalid !== want.inv)
          report_mismatch("calibration_invalid", out_if.calibration_invalid, want.inv);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Driver: on the falling edge, the sample channel either holds its word,
  // idles for a burst, or presents the next queued sample. Bursts only come in
  // busy stretches, so long runs without any idling occur too.
  // -------------------------------------------------------------------------
  int tx_gap;
  int tx_stretch;
  bit tx_busy;

  always @(negedge clk_i) begin
    logic          v;
    logic [SB-1:0] smp;
    v   = in_if.valid;
    smp = in_if.adc_sample;
    if (!rst_ni) begin
      v = 1'b0;
    end else if (!v || in_fire) begin
      v = 1'b0;
      if (tx_stretch == 0) begin
        tx_stretch = $urandom_range(20, 120);
        tx_busy    = ($urandom_range(0, 1) == 1);
      end else begin
        tx_stretch--;
      end
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (sample_q.size() > 0) begin
        if (!steady && tx_busy && $urandom_range(0, 3) == 0) begin
          tx_gap = $urandom_range(1, 16) - 1;
        end else begin
          v   = 1'b1;
          smp = sample_q.pop_front();
        end
      end
    end
    in_if.valid      <= v;
    in_if.adc_sample <= smp;
  end

  // -------------------------------------------------------------------------
  // Receiver: result ready with random stall bursts. Once, after a few
  // hundred results and with plenty of words still queued, it holds off for
  // a long stretch so that the output register fills and the block stops
  // taking input while the driver keeps offering words.
  // -------------------------------------------------------------------------
  int rx_stall;
  int rx_stretch;
  bit rx_busy;
  int hold_left;
  bit hold_done;

  always @(negedge clk_i) begin
    logic rdy;
    rdy = 1'b1;
    if (rx_stretch == 0) begin
      rx_stretch = $urandom_range(20, 120);
      rx_busy    = ($urandom_range(0, 1) == 1);
    end else begin
      rx_stretch--;
    end
    if (!hold_done && results_seen >= 300 && sample_q.size() > 16) begin
      hold_done = 1'b1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      rdy = 1'b0;
    end else if (!steady && rx_busy && $urandom_range(0, 3) == 0) begin
      rx_stall = $urandom_range(1, 16) - 1;
      rdy      = 1'b0;
    end
    out_if.ready <= rst_ni ? rdy : 1'b0;
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------

  // Writes one calibration register while the block is idle.
  task automatic write_calibration(input logic [tac_pkg::CfgIdxW-1:0] idx,
                                   input logic [SB-1:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == tac_pkg::CfgRegR30) cal_r30 = value;
    else if (idx == tac_pkg::CfgRegR85) cal_r85 = value;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Waits until every queued word has been taken and every reading returned.
  // The sender pauses here, so the block is idle before the next setting.
  task automatic wait_drained();
    while (sample_q.size() > 0 || in_if.valid || reading_q.size() > 0)
      @(posedge clk_i);
  endtask

  // Sensor-like samples: mostly a slowly wandering level with a little noise,
  // with some uniform values and the two rails mixed in.
  function automatic logic [SB-1:0] sensor_sample();
    int s;
    case ($urandom_range(0, 9)) inside
      0: s = $urandom_range(0, 1) ? AvgMax : 0;
      [1:2]: s = int'($urandom_range(0, AvgMax));
      default: begin
        if ($urandom_range(0, 15) == 0) sensor_level = int'($urandom_range(0, AvgMax));
        s = sensor_level + int'($urandom_range(0, 16)) - 8;
        if (s < 0) s = 0;
        if (s > AvgMax) s = AvgMax;
      end
    endcase
    return s[SB-1:0];
  endfunction

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin : stimulus
    int r30;
    int r85;
    // The opening words start at the first position of a period: one high
    // sample followed by zeros drives the sliding sum below zero once the
    // window is full; then a rising edge, alternating bit patterns and rails.
    static int opening [$] = '{4095, 0, 0, 0, 0, 0,
                               0, 4095, 4095, 4095, 4095, 4095, 4095,
                               2730, 1365, 1, 2048, 4094, 2047, 0, 4095};

    cfg_if.valid     = 1'b0;
    cfg_if.index     = tac_pkg::CfgRegR30;
    cfg_if.data      = '0;
    rst_ni           = 1'b0;

    cal_r30      = '0;
    cal_r85      = SB'(AvgMax);
    sensor_level = 2000;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Opening words under the calibration that reset leaves behind.
    n_settings = 1;
    foreach (opening[i]) sample_q.push_back(opening[i][SB-1:0]);
    wait_drained();

    // One calibration setting per phase: invalid, equal, the narrowest spans
    // at both rails (temperatures saturate both ways), a typical span, the
    // widest span, and random settings to finish.
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin r30 = AvgMax; r85 = 0;      end
        1: begin r30 = 2000;   r85 = 2000;   end
        2: begin r30 = 0;      r85 = 1;      end
        3: begin r30 = AvgMax - 1; r85 = AvgMax; end
        4: begin r30 = 1000;   r85 = 3000;   end
        5: begin r30 = 0;      r85 = AvgMax; end
        6: begin
          r30 = $urandom_range(0, AvgMax);
          r85 = $urandom_range(0, AvgMax);
        end
        default: begin
          r30 = $urandom_range(0, 2500);
          r85 = r30 + $urandom_range(1, AvgMax - r30);
        end
      endcase
      write_calibration(tac_pkg::CfgRegR30, r30[SB-1:0]);
      write_calibration(tac_pkg::CfgRegR85, r85[SB-1:0]);
      n_settings++;
      // The final phase runs without idling on either side.
      if (p == NumPhases - 1) steady = 1'b1;
      repeat (PhaseWords) sample_q.push_back(sensor_sample());
      wait_drained();
    end

    // Allow for a stray word arriving after the last expected one.
    repeat (100) @(posedge clk_i);
    if (reading_q.size() > 0)
      report_mismatch("readings never returned", 0, reading_q.size());

    $display("Sent %0d samples under %0d calibration settings;", words_in, n_settings);
    $display("  %0d period wraps, %0d floored sums.", n_wraps, n_floored);
    $display("Checked %0d results: %0d with invalid calibration, %0d saturated values.",
             results_seen, n_invalid, n_saturated);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
